/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the LED command parser.
// Relies on clk and rst_n being visible in the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/ipd_led_pkg.sv */
// Package for the LED command parser: event codes, control characters and
// the command word tables. No dependencies.
`default_nettype none

package ipd_led_pkg;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_ALLON     = 4'd1,
    EV_ALLOFF    = 4'd2,
    EV_LEDON     = 4'd3,
    EV_LEDOFF    = 4'd4,
    EV_BADSUFFIX = 4'd5,
    EV_BADNUMBER = 4'd6,
    EV_UNKNOWN   = 4'd7,
    EV_OVERFLOW  = 4'd8,
    EV_IGNORED   = 4'd9
  } event_t;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Word tables: a position past the end yields NUL, which never matches
  // since NUL bytes are handled before any comparison.
  function automatic logic [7:0] prefix_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "+";
      4'd1:    c = "I";
      4'd2:    c = "P";
      4'd3:    c = "D";
      4'd4:    c = ",";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] allon_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "a";
      4'd1:    c = "l";
      4'd2:    c = "l";
      4'd3:    c = "_";
      4'd4:    c = "l";
      4'd5:    c = "e";
      4'd6:    c = "d";
      4'd7:    c = "_";
      4'd8:    c = "o";
      4'd9:    c = "n";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] alloff_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "a";
      4'd1:    c = "l";
      4'd2:    c = "l";
      4'd3:    c = "_";
      4'd4:    c = "l";
      4'd5:    c = "e";
      4'd6:    c = "d";
      4'd7:    c = "_";
      4'd8:    c = "o";
      4'd9:    c = "f";
      4'd10:   c = "f";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] led_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "l";
      4'd1:    c = "e";
      4'd2:    c = "d";
      4'd3:    c = "_";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] on_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "_";
      4'd1:    c = "o";
      4'd2:    c = "n";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] off_char(input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:    c = "_";
      4'd1:    c = "o";
      4'd2:    c = "f";
      4'd3:    c = "f";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/ipd_line_led_command_parser.sv */
// LED command parser: line assembly, "+IPD," command decode and LED mask.
// Depends on ipd_led_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte) carries one received byte per
//   transaction. Output channel (out_valid, out_stall, out_leds, out_event_res)
//   returns exactly one result per byte: the LED mask after that byte and an
//   event code (none, command outcome, overflow or ignored line).
//   CR or LF closes a line and applies its command; an over-long line drops
//   the byte and restarts with an overflow event.
//   A byte is captured in the input register; the decode of the input register
//   loads the result register once the result register is free.
//   Throughput is one byte per cycle while out_stall does not hold the result;
//   the decode is a single combinational pass over the byte and the parser state.
//   Synchronous active-low reset empties both registers, restarts the line
//   and switches all LEDs off.
//   A stalled result holds; the input register keeps filling behind it, and
//   in_stall rises only once both stages hold a transaction.
`default_nettype none
`include "assert_macros.svh"

module ipd_line_led_command_parser #(
  parameter int LINE_BYTES = 128,
  parameter int LED_COUNT  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_leds,
  output logic [3:0]       out_event_res
);

  localparam int LEN_W = $clog2(LINE_BYTES);
  localparam int NUM_W = $clog2(LED_COUNT + 1);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);
  localparam logic [NUM_W-1:0] NUM_SAT  = NUM_W'(LED_COUNT);

  typedef enum logic [3:0] {
    ST_PREFIX, ST_COLON, ST_CMD, ST_NUM_FIRST, ST_NUM_WS, ST_NUM_SIGN,
    ST_NUM_DIG, ST_SUFFIX, ST_ALLON, ST_ALLOFF, ST_LEDON, ST_LEDOFF,
    ST_BADSUFFIX, ST_BADNUM, ST_UNKNOWN, ST_IGNORE
  } stage_t;

  // Input register and result register
  logic                 v1_r;
  logic [7:0]           byte_r;
  logic                 out_valid_r;
  logic [15:0]          out_leds_r;
  ipd_led_pkg::event_t  out_ev_r;

  // Parser state
  stage_t               stage_r, stage_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [3:0]           mp_r, mp_nxt;
  logic [2:0]           cf_r, cf_nxt;
  logic [NUM_W-1:0]     nv_r, nv_nxt;
  logic                 neg_r, neg_nxt;
  logic [LED_COUNT-1:0] led_r, led_nxt;
  ipd_led_pkg::event_t  ev_nxt;

  logic out_free, adv;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = v1_r && out_free;
  assign in_stall = v1_r && !out_free;

  // Byte classes
  logic       is_eol, is_digit, is_space, is_sign;
  logic [3:0] dig;
  assign is_eol   = (byte_r == ipd_led_pkg::CH_LF) || (byte_r == ipd_led_pkg::CH_CR);
  assign is_digit = (byte_r >= ipd_led_pkg::CH_ZERO) && (byte_r <= ipd_led_pkg::CH_NINE);
  assign is_space = (byte_r == ipd_led_pkg::CH_SPACE) ||
                    ((byte_r >= ipd_led_pkg::CH_TAB) && (byte_r <= ipd_led_pkg::CH_CR));
  assign is_sign  = (byte_r == ipd_led_pkg::CH_PLUS) || (byte_r == ipd_led_pkg::CH_MINUS);
  assign dig      = byte_r[3:0];

  // Number accumulation, saturating at LED_COUNT
  logic [9:0]       acc_sum, first_sum;
  logic [NUM_W-1:0] nv_acc, nv_first;
  assign acc_sum   = 10'(nv_r) * 10'd10 + 10'(dig);
  assign first_sum = 10'(dig);
  assign nv_acc    = (acc_sum > 10'(LED_COUNT)) ? NUM_SAT : NUM_W'(acc_sum);
  assign nv_first  = (first_sum > 10'(LED_COUNT)) ? NUM_SAT : NUM_W'(first_sum);

  logic number_bad;
  assign number_bad = (neg_r && (nv_r != '0)) || (nv_r >= NUM_SAT);

  // Stage after the text ends
  stage_t stage_fin;
  always_comb begin
    case (stage_r)
      ST_PREFIX, ST_COLON: stage_fin = ST_IGNORE;
      ST_CMD:              stage_fin = ST_UNKNOWN;
      ST_NUM_FIRST, ST_NUM_WS, ST_NUM_SIGN, ST_SUFFIX:
        stage_fin = ST_BADSUFFIX;
      ST_NUM_DIG:          stage_fin = number_bad ? ST_BADNUM : ST_BADSUFFIX;
      default:             stage_fin = stage_r;
    endcase
  end

  // Command word match
  logic [2:0] cmd_f;
  always_comb begin
    cmd_f = cf_r;
    if (byte_r != ipd_led_pkg::allon_char(mp_r))  cmd_f[0] = 1'b0;
    if (byte_r != ipd_led_pkg::alloff_char(mp_r)) cmd_f[1] = 1'b0;
    if (byte_r != ipd_led_pkg::led_char(mp_r))    cmd_f[2] = 1'b0;
  end

  // Suffix match; a fresh suffix starts at position zero with both candidates
  logic [3:0] sfx_p;
  logic [1:0] sfx_f;
  always_comb begin
    sfx_p = (stage_r == ST_SUFFIX) ? mp_r : 4'd0;
    sfx_f = (stage_r == ST_SUFFIX) ? cf_r[1:0] : 2'b11;
    if (byte_r != ipd_led_pkg::on_char(sfx_p))  sfx_f[0] = 1'b0;
    if (byte_r != ipd_led_pkg::off_char(sfx_p)) sfx_f[1] = 1'b0;
  end

  stage_t     sfx_stage;
  logic [3:0] sfx_mp;
  logic [2:0] sfx_cf;
  always_comb begin
    sfx_stage = ST_SUFFIX;
    sfx_mp    = sfx_p + 4'd1;
    sfx_cf    = {1'b0, sfx_f};
    if (sfx_f[0] && (sfx_p == 4'd2)) begin
      sfx_stage = ST_LEDON;
    end else if (sfx_f[1] && (sfx_p == 4'd3)) begin
      sfx_stage = ST_LEDOFF;
    end else if (sfx_f == 2'b00) begin
      sfx_stage = ST_BADSUFFIX;
    end
  end

  logic [LED_COUNT-1:0] led_bit;
  assign led_bit = LED_COUNT'(1) << nv_r;

  always_comb begin
    stage_nxt = stage_r;
    len_nxt   = len_r;
    mp_nxt    = mp_r;
    cf_nxt    = cf_r;
    nv_nxt    = nv_r;
    neg_nxt   = neg_r;
    led_nxt   = led_r;
    ev_nxt    = ipd_led_pkg::EV_NONE;
    if (is_eol) begin
      unique case (stage_fin)
        ST_ALLON: begin
          led_nxt = '1;
          ev_nxt  = ipd_led_pkg::EV_ALLON;
        end
        ST_ALLOFF: begin
          led_nxt = '0;
          ev_nxt  = ipd_led_pkg::EV_ALLOFF;
        end
        ST_LEDON: begin
          led_nxt = led_r | led_bit;
          ev_nxt  = ipd_led_pkg::EV_LEDON;
        end
        ST_LEDOFF: begin
          led_nxt = led_r & ~led_bit;
          ev_nxt  = ipd_led_pkg::EV_LEDOFF;
        end
        ST_BADSUFFIX: ev_nxt = ipd_led_pkg::EV_BADSUFFIX;
        ST_BADNUM:    ev_nxt = ipd_led_pkg::EV_BADNUMBER;
        ST_UNKNOWN:   ev_nxt = ipd_led_pkg::EV_UNKNOWN;
        default:      ev_nxt = ipd_led_pkg::EV_IGNORED;
      endcase
      stage_nxt = ST_PREFIX;
      len_nxt   = '0;
      mp_nxt    = '0;
      cf_nxt    = '0;
      nv_nxt    = '0;
      neg_nxt   = 1'b0;
    end else if (len_r == LEN_LAST) begin
      stage_nxt = ST_PREFIX;
      len_nxt   = '0;
      mp_nxt    = '0;
      cf_nxt    = '0;
      nv_nxt    = '0;
      neg_nxt   = 1'b0;
      ev_nxt    = ipd_led_pkg::EV_OVERFLOW;
    end else begin
      len_nxt = len_r + LEN_W'(1);
      if (byte_r == ipd_led_pkg::CH_NUL) begin
        stage_nxt = stage_fin;
      end else begin
        unique case (stage_r)
          ST_PREFIX: begin
            if (byte_r == ipd_led_pkg::prefix_char(mp_r)) begin
              mp_nxt = mp_r + 4'd1;
              if (mp_r == 4'd4) stage_nxt = ST_COLON;
            end else begin
              stage_nxt = ST_IGNORE;
            end
          end
          ST_COLON: begin
            if (byte_r == ipd_led_pkg::CH_COLON) begin
              stage_nxt = ST_CMD;
              mp_nxt    = '0;
              cf_nxt    = 3'b111;
            end
          end
          ST_CMD: begin
            if (cmd_f[0] && (mp_r == 4'd9)) begin
              stage_nxt = ST_ALLON;
            end else if (cmd_f[1] && (mp_r == 4'd10)) begin
              stage_nxt = ST_ALLOFF;
            end else if (cmd_f[2] && (mp_r == 4'd3)) begin
              stage_nxt = ST_NUM_FIRST;
              nv_nxt    = '0;
              neg_nxt   = 1'b0;
            end else if (cmd_f == 3'b000) begin
              stage_nxt = ST_UNKNOWN;
            end else begin
              cf_nxt = cmd_f;
              mp_nxt = mp_r + 4'd1;
            end
          end
          ST_NUM_FIRST, ST_NUM_WS: begin
            if (is_digit) begin
              stage_nxt = ST_NUM_DIG;
              nv_nxt    = nv_first;
            end else if (is_space) begin
              stage_nxt = ST_NUM_WS;
            end else if (is_sign) begin
              stage_nxt = ST_NUM_SIGN;
              neg_nxt   = (byte_r == ipd_led_pkg::CH_MINUS);
            end else if (stage_r == ST_NUM_FIRST) begin
              stage_nxt = sfx_stage;
              mp_nxt    = sfx_mp;
              cf_nxt    = sfx_cf;
            end else begin
              stage_nxt = ST_BADSUFFIX;
            end
          end
          ST_NUM_SIGN: begin
            if (is_digit) begin
              stage_nxt = ST_NUM_DIG;
              nv_nxt    = nv_first;
            end else begin
              stage_nxt = ST_BADSUFFIX;
            end
          end
          ST_NUM_DIG: begin
            if (is_digit) begin
              nv_nxt = nv_acc;
            end else if (number_bad) begin
              stage_nxt = ST_BADNUM;
            end else begin
              stage_nxt = sfx_stage;
              mp_nxt    = sfx_mp;
              cf_nxt    = sfx_cf;
            end
          end
          ST_SUFFIX: begin
            stage_nxt = sfx_stage;
            mp_nxt    = sfx_mp;
            cf_nxt    = sfx_cf;
          end
          default: stage_nxt = stage_r;
        endcase
      end
    end
  end

  logic [31:0] led_ext;
  assign led_ext = 32'(led_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      stage_r     <= ST_PREFIX;
      len_r       <= '0;
      mp_r        <= '0;
      cf_r        <= '0;
      nv_r        <= '0;
      neg_r       <= 1'b0;
      led_r       <= '0;
    end else begin
      if (!in_stall) begin
        v1_r <= in_valid;
      end
      if (in_valid && !in_stall) begin
        byte_r <= in_byte;
      end
      if (out_free) begin
        out_valid_r <= v1_r;
      end
      if (adv) begin
        out_leds_r <= led_ext[15:0];
        out_ev_r   <= ev_nxt;
        stage_r    <= stage_nxt;
        len_r      <= len_nxt;
        mp_r       <= mp_nxt;
        cf_r       <= cf_nxt;
        nv_r       <= nv_nxt;
        neg_r      <= neg_nxt;
        led_r      <= led_nxt;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_leds      = out_leds_r;
  assign out_event_res = out_ev_r;

  logic line_idle, cmd_event;
  assign line_idle = (len_r == '0) && (stage_r == ST_PREFIX);
  assign cmd_event = (ev_nxt == ipd_led_pkg::EV_ALLON) || (ev_nxt == ipd_led_pkg::EV_ALLOFF) ||
                     (ev_nxt == ipd_led_pkg::EV_LEDON) || (ev_nxt == ipd_led_pkg::EV_LEDOFF);

  `ASSERT_ALWAYS(a_len_in_range, (len_r <= LEN_LAST) && (nv_r <= NUM_SAT), "state out of range")
  `ASSERT_NEXT(a_eol_restarts, adv && is_eol, line_idle, "line not restarted after line end")
  `ASSERT_SAME(a_leds_only_on_cmd, adv && !cmd_event, led_nxt == led_r, "LED mask changed")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for ipd_line_led_command_parser: a table of directed lines,
// then random "+IPD," traffic; bytes are checked against a behavioural parser or,
// for typed line ends, the table. Depends on ipd_led_pkg and the parser RTL.
module testbench;
  import ipd_led_pkg::*;

  localparam int LINE_BYTES     = 128;
  localparam int LED_COUNT      = 16;
  localparam int RANDOM_BYTES   = 950;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [3:0] {
    PS_PREFIX, PS_COLON, PS_CMD, PS_NUM_FIRST, PS_NUM_WS, PS_NUM_SIGN, PS_NUM_DIG,
    PS_SUFFIX, PS_ALLON, PS_ALLOFF, PS_LEDON, PS_LEDOFF, PS_BADSUFFIX, PS_BADNUM,
    PS_UNKNOWN, PS_IGNORE
  } parse_stage_t;

  typedef struct packed {
    logic [15:0] leds;
    event_t      ev;
  } led_result_t;

  typedef struct {
    string       text;
    int          nul_at;
    int          pad;
    logic [7:0]  term;
    bit          typed;
    logic [15:0] leds;
    event_t      ev;
  } line_case_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_leds;
  logic [3:0]  out_event_res;

  ipd_line_led_command_parser #(
    .LINE_BYTES(LINE_BYTES),
    .LED_COUNT (LED_COUNT)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_leds     (out_leds),
    .out_event_res(out_event_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser model state
  int           line_len;
  parse_stage_t stage;
  int           pos;
  logic [2:0]   cand;
  int           num;
  bit           neg;
  logic [15:0]  model_leds;

  string word_prefix = "+IPD,";
  string word_allon  = "all_led\137on";
  string word_alloff = "all_led\137off";
  string word_led    = "led_";
  string word_on     = "_on";
  string word_off    = "_off";

  string odd_commands [6] = '{"all_led", "led", "", "all_led_of", "ALL_LED\137ON", "led3_on"};
  string odd_suffixes [7] = '{"_o", "_of", "on", "", "_onx", "_off_on", "__on"};

  line_case_t directed_lines [24] = '{
    '{"",                             -1,   0, CH_LF, 1'b1, 16'h0000, EV_IGNORED},
    '{"+IPD,0:all_led\137on",         -1,   0, CH_CR, 1'b1, 16'hFFFF, EV_ALLON},
    '{"",                             -1,   0, CH_LF, 1'b1, 16'hFFFF, EV_IGNORED},
    '{"+IPD,12:led_3_off",            -1,   0, CH_LF, 1'b1, 16'hFFF7, EV_LEDOFF},
    '{"+IPD,0:led_16_on",             -1,   0, CH_CR, 1'b1, 16'hFFF7, EV_BADNUMBER},
    '{"+IPD,0:led_-3_on",             -1,   0, CH_LF, 1'b1, 16'hFFF7, EV_BADNUMBER},
    '{"+IPD,0:led_99999999999_off",   -1,   0, CH_LF, 1'b1, 16'hFFF7, EV_BADNUMBER},
    '{"+IPD,x:all_led\137off",        -1,   0, CH_LF, 1'b1, 16'h0000, EV_ALLOFF},
    '{"+IPD,0:led_15_on",             -1,   0, CH_CR, 1'b1, 16'h8000, EV_LEDON},
    '{"+IPD,0:led_ -0_on",            -1,   0, CH_LF, 1'b0, 16'h0000, EV_NONE},
    '{"+IPD,0:led__on",               -1,   0, CH_LF, 1'b0, 16'h0000, EV_NONE},
    '{"+IPD,0:led_ _on",              -1,   0, CH_LF, 1'b1, 16'h8001, EV_BADSUFFIX},
    '{"+IPD,0:led_3_onX",             -1,   0, CH_LF, 1'b0, 16'h0000, EV_NONE},
    '{"+IPD,0:led_+3_o",              -1,   0, CH_LF, 1'b1, 16'h8009, EV_BADSUFFIX},
    '{"+IPD,0:blink",                 -1,   0, CH_CR, 1'b1, 16'h8009, EV_UNKNOWN},
    '{"+IPD,0:",                      -1,   0, CH_LF, 1'b1, 16'h8009, EV_UNKNOWN},
    '{"+IPD,0",                       -1,   0, CH_LF, 1'b1, 16'h8009, EV_IGNORED},
    '{"AT+IPD,0:all_led\137on",       -1,   0, CH_LF, 1'b1, 16'h8009, EV_IGNORED},
    '{"+IPD,0:led_5_on",              12,   0, CH_LF, 1'b1, 16'h8009, EV_BADSUFFIX},
    '{"+IPD,0:all_led\137onzz",       17,   0, CH_CR, 1'b1, 16'hFFFF, EV_ALLON},
    '{"+IPD,\377\200:led_ \t7_off",   -1,   0, CH_LF, 1'b0, 16'h0000, EV_NONE},
    '{"+IPD,0:all_led\137off",        -1, 109, CH_LF, 1'b1, 16'h0000, EV_ALLOFF},
    '{"",                             -1, 130, CH_LF, 1'b1, 16'h0000, EV_IGNORED},
    '{"+IPD,0:led_0_on",              -1,   0, CH_CR, 1'b1, 16'h0001, EV_LEDON}
  };

  led_result_t led_events_due [$];
  logic [7:0]  line_buf [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic bit word_hit(input string w, input int p, input logic [7:0] c);
    return p < w.len() && c == w[p];
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit number_bad();
    return (neg && num != 0) || num >= LED_COUNT;
  endfunction

  function automatic void restart_line();
    line_len = 0;
    stage    = PS_PREFIX;
    pos      = 0;
    cand     = '0;
    num      = 0;
    neg      = 1'b0;
  endfunction

  function automatic void suffix_step(input logic [7:0] c);
    logic [2:0] f;
    f = cand;
    if (!word_hit(word_on, pos, c)) f[0] = 1'b0;
    if (!word_hit(word_off, pos, c)) f[1] = 1'b0;
    if (f[0] && pos + 1 == word_on.len()) stage = PS_LEDON;
    else if (f[1] && pos + 1 == word_off.len()) stage = PS_LEDOFF;
    else if (f == '0) stage = PS_BADSUFFIX;
    else begin
      cand = f;
      pos  = pos + 1;
    end
  endfunction

  function automatic void start_suffix(input logic [7:0] c);
    stage = PS_SUFFIX;
    pos   = 0;
    cand  = 3'b011;
    suffix_step(c);
  endfunction

  // text ended (NUL or line end) before the parse settled
  function automatic void close_text();
    case (stage)
      PS_PREFIX, PS_COLON: stage = PS_IGNORE;
      PS_CMD: stage = PS_UNKNOWN;
      PS_NUM_FIRST, PS_NUM_WS, PS_NUM_SIGN, PS_SUFFIX: stage = PS_BADSUFFIX;
      PS_NUM_DIG: stage = number_bad() ? PS_BADNUM : PS_BADSUFFIX;
      default: ;
    endcase
  endfunction

  function automatic void parse_step(input logic [7:0] c);
    logic [2:0] f;
    if (c == CH_NUL) begin
      close_text();
      return;
    end
    case (stage)
      PS_PREFIX: begin
        if (word_hit(word_prefix, pos, c)) begin
          pos = pos + 1;
          if (pos == word_prefix.len()) stage = PS_COLON;
        end else stage = PS_IGNORE;
      end
      PS_COLON: begin
        if (c == CH_COLON) begin
          stage = PS_CMD;
          pos   = 0;
          cand  = 3'b111;
        end
      end
      PS_CMD: begin
        f = cand;
        if (!word_hit(word_allon, pos, c)) f[0] = 1'b0;
        if (!word_hit(word_alloff, pos, c)) f[1] = 1'b0;
        if (!word_hit(word_led, pos, c)) f[2] = 1'b0;
        if (f[0] && pos + 1 == word_allon.len()) stage = PS_ALLON;
        else if (f[1] && pos + 1 == word_alloff.len()) stage = PS_ALLOFF;
        else if (f[2] && pos + 1 == word_led.len()) begin
          stage = PS_NUM_FIRST;
          num   = 0;
          neg   = 1'b0;
        end else if (f == '0) stage = PS_UNKNOWN;
        else begin
          cand = f;
          pos  = pos + 1;
        end
      end
      PS_NUM_FIRST, PS_NUM_WS: begin
        if (is_digit(c)) begin
          stage = PS_NUM_DIG;
          num   = c - CH_ZERO;
          if (num > LED_COUNT) num = LED_COUNT;
        end else if (is_space(c)) stage = PS_NUM_WS;
        else if (c == CH_PLUS || c == CH_MINUS) begin
          stage = PS_NUM_SIGN;
          neg   = (c == CH_MINUS);
        end else if (stage == PS_NUM_FIRST) start_suffix(c);
        else stage = PS_BADSUFFIX;
      end
      PS_NUM_SIGN: begin
        if (is_digit(c)) begin
          stage = PS_NUM_DIG;
          num   = c - CH_ZERO;
          if (num > LED_COUNT) num = LED_COUNT;
        end else stage = PS_BADSUFFIX;
      end
      PS_NUM_DIG: begin
        if (is_digit(c)) begin
          num = num * 10 + (c - CH_ZERO);
          if (num > LED_COUNT) num = LED_COUNT;
        end else if (number_bad()) stage = PS_BADNUM;
        else start_suffix(c);
      end
      PS_SUFFIX: suffix_step(c);
      default: ;
    endcase
  endfunction

  function automatic led_result_t parse_led_byte(input logic [7:0] c);
    led_result_t r;
    logic [15:0] led_bit;
    r.ev = EV_NONE;
    if (c == CH_LF || c == CH_CR) begin
      close_text();
      led_bit = (num < LED_COUNT) ? 16'(32'd1 << num) : 16'h0000;
      case (stage)
        PS_ALLON: begin
          model_leds = '1;
          r.ev = EV_ALLON;
        end
        PS_ALLOFF: begin
          model_leds = '0;
          r.ev = EV_ALLOFF;
        end
        PS_LEDON: begin
          model_leds = model_leds | led_bit;
          r.ev = EV_LEDON;
        end
        PS_LEDOFF: begin
          model_leds = model_leds & ~led_bit;
          r.ev = EV_LEDOFF;
        end
        PS_BADSUFFIX: r.ev = EV_BADSUFFIX;
        PS_BADNUM: r.ev = EV_BADNUMBER;
        PS_UNKNOWN: r.ev = EV_UNKNOWN;
        default: r.ev = EV_IGNORED;
      endcase
      restart_line();
    end else if (line_len < LINE_BYTES - 1) begin
      line_len = line_len + 1;
      parse_step(c);
    end else begin
      restart_line();
      r.ev = EV_OVERFLOW;
    end
    r.leds = model_leds;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [15:0] t_leds,
                           input event_t t_ev);
    led_result_t due;
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    due = parse_led_byte(b);
    if (typed) begin
      due.leds = t_leds;
      due.ev   = t_ev;
    end
    led_events_due.push_back(due);
    bytes_sent++;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic string number_text();
    string s;
    int r;
    s = "";
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) != 0) s = " ";
      else s = "\t ";
    end
    r = $urandom_range(99);
    if (r < 10) s = {s, "+"};
    else if (r < 20) s = {s, "-"};
    r = $urandom_range(99);
    if (r < 8) s = {s, "0", $sformatf("%0d", $urandom_range(15))};
    else if (r < 80) s = {s, $sformatf("%0d", $urandom_range(15))};
    else if (r < 90) s = {s, $sformatf("%0d", $urandom_range(99999, 16))};
    else if (r < 94) begin
      repeat ($urandom_range(20, 8)) s = {s, $sformatf("%0d", $urandom_range(9))};
    end
    return s;
  endfunction

  function automatic void build_random_line();
    int kind;
    int sel;
    logic [7:0] b;
    line_buf.delete();
    push_text($sformatf("+IPD,%0d,%0d:", $urandom_range(4), $urandom_range(40)));
    sel = $urandom_range(9);
    if (sel == 0) push_text(word_allon);
    else if (sel == 1) push_text(word_alloff);
    else if (sel == 2) push_text(odd_commands[$urandom_range(5)]);
    else begin
      push_text(word_led);
      push_text(number_text());
      if ($urandom_range(99) < 90) push_text(($urandom_range(1) != 0) ? word_on : word_off);
      else push_text(odd_suffixes[$urandom_range(6)]);
    end
    if ($urandom_range(3) == 0) push_text("xyz");
    kind = $urandom_range(99);
    if (kind < 70) ;
    else if (kind < 78) begin
      line_buf.delete();
      repeat ($urandom_range(24)) line_buf.push_back(8'($urandom_range(255)));
    end else if (kind < 86) begin
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 93) line_buf.insert($urandom_range(line_buf.size()), CH_NUL);
    else if (kind < 96) begin
      repeat ($urandom_range(200, 110)) begin
        b = 8'($urandom_range(255));
        line_buf.push_back((b == CH_LF || b == CH_CR) ? 8'h78 : b);
      end
    end else begin
      repeat ($urandom_range(line_buf.size() - 1)) void'(line_buf.pop_back());
    end
    sel = $urandom_range(2);
    if (sel == 0) line_buf.push_back(CH_LF);
    else line_buf.push_back(CH_CR);
    if (sel == 2) line_buf.push_back(CH_LF);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else out_stall <= !calm && ($urandom_range(99) < 10);
    end
  end

  always @(posedge clk) begin
    led_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (led_events_due.size() == 0) begin
        $error("unexpected transaction: leds %h event_res %0d", out_leds, out_event_res);
        mismatches++;
      end else begin
        want = led_events_due.pop_front();
        if (out_leds !== want.leds) begin
          $error("leds: expected %h, actual %h", want.leds, out_leds);
          mismatches++;
        end
        if (out_event_res !== want.ev) begin
          $error("event_res: expected %0d, actual %0d", want.ev, out_event_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int line_no;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = '0;
    restart_line();
    model_leds = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_lines[k]) begin
      for (int i = 0; i < directed_lines[k].text.len(); i++) begin
        if (i == directed_lines[k].nul_at) send_byte(CH_NUL, 1'b0, '0, EV_NONE);
        send_byte(directed_lines[k].text[i], 1'b0, '0, EV_NONE);
      end
      repeat (directed_lines[k].pad) send_byte(8'h71, 1'b0, '0, EV_NONE);
      send_byte(directed_lines[k].term, directed_lines[k].typed, directed_lines[k].leds,
                directed_lines[k].ev);
    end

    bytes_sent = 0;
    line_no    = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      build_random_line();
      calm = (line_no >= 20 && line_no < 32);
      if (line_no == 8) hold_req = 1'b1;
      if (line_no == 14) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (led_events_due.size() != 0);
      end
      foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, '0, EV_NONE);
      line_no++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (led_events_due.size() != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
